// File: design/sfq_pkg.sv
package sfq_pkg;

  // Operation codes carried on opcode_i
  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_SORT = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  // Result status codes carried on status_o
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE       = 5'b00001,
    ST_GET_WAIT   = 5'b00010,
    ST_SORT_KEY   = 5'b00100,
    ST_SORT_CMP   = 5'b01000,
    ST_SORT_PLACE = 5'b10000
  } state_e;

endpackage

// File: design/sfq_ram.sv
module sfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a same-address read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sortable_fifo_queue.sv
// Sortable FIFO queue of signed values kept in a ring buffer of DEPTH entries in one
// synchronous RAM (one write port, one registered read port). Each transaction on the
// input channel yields exactly one result transaction. A put, a no-op, a full put, an
// empty get and a sort of zero or one values load the result on acceptance; a get waits
// in ST_GET_WAIT for the registered RAM read. A sort runs an in-place stable insertion
// sort over the held values through the single RAM port pair: for each key it fetches the
// key, shifts larger neighbors right and places the key, and the input channel stays
// stalled until the sort result is loaded. A new transaction is taken only while the
// sequencer is idle and the output register is empty or being drained in the same cycle.
module sortable_fifo_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  sfq_pkg::opcode_e                  opcode_i,
  input  logic signed [31:0]                value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                data_o,
  output sfq_pkg::status_e                  status_o,
  output logic                              is_empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        fill_count_o
);

  import sfq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Ring position helpers with wrap at DEPTH (DEPTH need not be a power of two)
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  state_e state_q, state_d;

  logic [AW-1:0] rd_pos_q, rd_pos_d;
  logic [AW-1:0] wr_pos_q, wr_pos_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Sort bookkeeping: pi is the slot of the current key, pj the hole it moves down to
  logic [AW-1:0]                pi_q, pi_d;
  logic [AW-1:0]                pj_q, pj_d;
  logic signed [DATA_WIDTH-1:0] key_q, key_d;

  // RAM ports
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic signed [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic signed [DATA_WIDTH-1:0] ram_rdata;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] data_q;
  status_e            status_q;
  logic               empty_q;
  logic [CW-1:0]      fill_q;

  logic               in_accept;
  logic               out_free;
  logic               load;
  logic signed [31:0] ld_data;
  status_e            ld_status;
  logic               next_key;

  sfq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Take a transaction only when idle and a result slot is available this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    rd_pos_d  = rd_pos_q;
    wr_pos_d  = wr_pos_q;
    cnt_d     = cnt_q;
    pi_d      = pi_q;
    pj_d      = pj_q;
    key_d     = key_q;
    ram_we    = 1'b0;
    ram_waddr = pj_q;
    ram_wdata = key_q;
    ram_raddr = pi_q;
    load      = 1'b0;
    ld_data   = '0;
    ld_status = STAT_OK;
    next_key  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Point the read port at the head so a get has its data next cycle
        ram_raddr = rd_pos_q;
        if (in_accept) begin
          unique case (opcode_i)
            OP_PUT: begin
              load = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                ld_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wr_pos_q;
                ram_wdata = DATA_WIDTH'(value_i);
                wr_pos_d  = ptr_inc(wr_pos_q);
                cnt_d     = cnt_q + 1'b1;
              end
            end
            OP_GET: begin
              if (cnt_q == '0) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
              end else begin
                state_d = ST_GET_WAIT;
              end
            end
            OP_SORT: begin
              if (cnt_q == '0) begin
                load      = 1'b1;
                ld_status = STAT_EMPTY;
              end else if (cnt_q == CW'(1)) begin
                load = 1'b1;
              end else begin
                // First key is the second value from the head
                ram_raddr = ptr_inc(rd_pos_q);
                pi_d      = ptr_inc(rd_pos_q);
                state_d   = ST_SORT_KEY;
              end
            end
            OP_NOP: begin
              load = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      ST_GET_WAIT: begin
        // Pop the head; the output register is free since nothing loaded on accept
        ram_raddr = rd_pos_q;
        load      = 1'b1;
        ld_data   = 32'(ram_rdata);
        rd_pos_d  = ptr_inc(rd_pos_q);
        cnt_d     = cnt_q - 1'b1;
        state_d   = ST_IDLE;
      end

      ST_SORT_KEY: begin
        // Capture the key and fetch its left neighbor
        key_d     = ram_rdata;
        pj_d      = pi_q;
        ram_raddr = ptr_dec(pi_q);
        state_d   = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        if (ram_rdata > key_q) begin
          // Shift the larger neighbor right into the hole and move the hole left
          ram_we    = 1'b1;
          ram_waddr = pj_q;
          ram_wdata = ram_rdata;
          pj_d      = ptr_dec(pj_q);
          ram_raddr = ptr_dec(ptr_dec(pj_q));
          if (ptr_dec(pj_q) == rd_pos_q) begin
            state_d = ST_SORT_PLACE;
          end
        end else begin
          // Neighbor not greater: drop the key into the hole (keeps equal values stable)
          ram_we    = 1'b1;
          ram_waddr = pj_q;
          ram_wdata = key_q;
          next_key  = 1'b1;
        end
      end

      ST_SORT_PLACE: begin
        // Hole reached the head: place the key there
        ram_we    = 1'b1;
        ram_waddr = pj_q;
        ram_wdata = key_q;
        next_key  = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Advance to the next key, or finish when the tail has been reached
    if (next_key) begin
      if (ptr_inc(pi_q) == wr_pos_q) begin
        load    = 1'b1;
        state_d = ST_IDLE;
      end else begin
        pi_d      = ptr_inc(pi_q);
        ram_raddr = ptr_inc(pi_q);
        state_d   = ST_SORT_KEY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_pos_q <= rd_pos_d;
      wr_pos_q <= wr_pos_d;
      cnt_q    <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sort scratch and result payload: no reset needed
  always_ff @(posedge clk_i) begin
    pi_q  <= pi_d;
    pj_q  <= pj_d;
    key_q <= key_d;
    if (load) begin
      data_q   <= ld_data;
      status_q <= ld_status;
      empty_q  <= (cnt_d == '0);
      fill_q   <= cnt_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_o       = data_q;
  assign status_o     = status_q;
  assign is_empty_o   = empty_q;
  assign fill_count_o = fill_q;

  // Expected tail position from head and count, for the ring consistency check
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail_exp;

  always_comb begin
    tail_sum = {1'b0, rd_pos_q} + (AW + 1)'(cnt_q);
    if (tail_sum >= (AW + 1)'(DEPTH)) begin
      tail_exp = AW'(tail_sum - (AW + 1)'(DEPTH));
    end else begin
      tail_exp = AW'(tail_sum);
    end
  end

  // Tail always sits count slots after the head
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pos_q == tail_exp)
    else $error("write position out of step with read position and count");

  // A result is never loaded over one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free)
    else $error("result loaded while output register busy");

  // A get on a non-empty queue waits in ST_GET_WAIT for the RAM read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && opcode_i == OP_GET && cnt_q != '0) |=> (state_q == ST_GET_WAIT))
    else $error("get did not wait for RAM read data");

  // The sequencer only leaves idle while the queue holds values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (cnt_q != '0))
    else $error("sequencer busy on an empty queue");

endmodule

// File: dv/tb.sv
module tb;
  import sfq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned FILL_W     = $clog2(DEPTH + 1);
  localparam int          ITEM_GOAL  = 1450;
  localparam int          CALM_FROM  = 1250;
  localparam int          CYCLE_CAP  = 600000;

  // One expected result transaction
  typedef struct packed {
    logic signed [31:0] data;
    status_e            status;
    logic               empty;
    logic [FILL_W-1:0]  fill;
  } queue_result_t;

  // Shadow copy of the queue: predicts each result and checks what comes out
  class queue_scoreboard;
    localparam int CAP = 16;
    logic signed [31:0] slots [CAP];
    int unsigned        head;
    int unsigned        tail;
    int unsigned        held;
    queue_result_t      pending [$];
    int                 errors;

    function new();
      head = 0;
      tail = 0;
      held = 0;
      errors = 0;
    endfunction

    // Stable insertion sort over the held values, in order from the head
    function void sort_in_place();
      logic signed [31:0] line [CAP];
      logic signed [31:0] key;
      int j;
      for (int k = 0; k < held; k++) line[k] = slots[(head + k) % CAP];
      for (int i = 1; i < held; i++) begin
        key = line[i];
        j = i;
        while (j > 0 && line[j-1] > key) begin
          line[j] = line[j-1];
          j--;
        end
        line[j] = key;
      end
      for (int k = 0; k < held; k++) slots[(head + k) % CAP] = line[k];
    endfunction

    // Apply one accepted input transaction and queue the result it must cause
    function void note_input(opcode_e op, logic signed [31:0] val);
      queue_result_t r;
      r.data   = '0;
      r.status = STAT_OK;
      case (op)
        OP_PUT: begin
          if (held >= CAP) begin
            r.status = STAT_FULL;
          end else begin
            slots[tail] = val;
            tail = (tail + 1) % CAP;
            held++;
          end
        end
        OP_GET: begin
          if (held == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            r.data = slots[head];
            head = (head + 1) % CAP;
            held--;
          end
        end
        OP_SORT: begin
          if (held == 0) r.status = STAT_EMPTY;
          else sort_in_place();
        end
        default: ;
      endcase
      r.empty = (held == 0);
      r.fill  = held[FILL_W-1:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    // Compare one accepted result transaction, field by field, with the oldest prediction
    task check_result(logic signed [31:0] data, status_e status, logic empty,
                      logic [FILL_W-1:0] fill);
      queue_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result data=%0d status=%0d", data, status));
      end else begin
        want = pending.pop_front();
        if (data !== want.data)
          report($sformatf("data %0d, want %0d", data, want.data));
        if (status !== want.status)
          report($sformatf("status %0d, want %0d", status, want.status));
        if (empty !== want.empty)
          report($sformatf("is_empty %0b, want %0b", empty, want.empty));
        if (fill !== want.fill)
          report($sformatf("fill_count %0d, want %0d", fill, want.fill));
      end
    endtask
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  opcode_e                  opcode_i;
  logic signed [31:0]       value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [31:0]       data_o;
  status_e                  status_o;
  logic                     is_empty_o;
  logic [FILL_W-1:0]        fill_count_o;

  queue_scoreboard sb;
  int  sent;
  int  cycles;
  bit  calm;

  sortable_fifo_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_o       (data_o),
    .status_o     (status_o),
    .is_empty_o   (is_empty_o),
    .fill_count_o (fill_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bound the run: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sample result transactions at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(data_o, status_o, is_empty_o, fill_count_o);
  end

  // Stall the result side in random bursts; hold ready high once the run calms down
  initial begin
    int stall_left;
    int quiet_left;
    stall_left = 0;
    quiet_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && stall_left == 0 && quiet_left == 0) begin
        case ($urandom_range(0, 19))
          0, 1, 2: stall_left = $urandom_range(1, 14);
          3:       quiet_left = $urandom_range(20, 80);
          default: ;
        endcase
      end
      if (!calm && stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (quiet_left > 0) quiet_left--;
      end
    end
  end

  // Drive one input transaction, starting and ending at a falling edge.
  // Drop valid for a random burst first, unless the run has calmed down.
  task automatic send_item(opcode_e op, logic signed [31:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, val);
    sent++;
    @(negedge clk_i);
  endtask

  // Mix wide random values with near-zero ones (duplicates) and the two extremes
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      1: v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin
    int seg_left;
    int put_pct;
    int pick;
    sb = new();
    sent = 0;
    cycles = 0;
    calm = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = OP_NOP;
    value_i = '0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty get, sort and no-op, extremes, a sort and a get, then fill to full, a full put and a no-op
    send_item(OP_GET, 32'sd0);
    send_item(OP_SORT, 32'sd0);
    send_item(OP_NOP, 32'sd0);
    send_item(OP_PUT, 32'sh7fff_ffff);
    send_item(OP_PUT, 32'sh8000_0000);
    send_item(OP_PUT, 32'sd0);
    send_item(OP_PUT, -32'sd1);
    send_item(OP_PUT, 32'sd1);
    send_item(OP_PUT, -32'sd1);
    send_item(OP_SORT, 32'sd0);
    send_item(OP_GET, 32'sd0);
    while (sb.held < DEPTH) send_item(OP_PUT, pick_value());
    send_item(OP_PUT, 32'sh5a5a_a5a5);
    send_item(OP_NOP, 32'sd0);

    // Random: segments that lean toward filling, draining or balance
    seg_left = 0;
    put_pct = 50;
    while (sent < ITEM_GOAL) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: put_pct = 15;
          1: put_pct = 50;
          default: put_pct = 85;
        endcase
      end
      seg_left--;
      calm = (sent >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_item(OP_SORT, pick_value());
      else if (pick < 7)
        send_item(OP_NOP, pick_value());
      else if (pick < 7 + (put_pct * 93) / 100)
        send_item(OP_PUT, pick_value());
      else
        send_item(OP_GET, pick_value());
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then let the block settle
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
design/sfq_pkg.sv
design/sfq_ram.sv
design/sortable_fifo_queue.sv
dv/tb.sv
